// ===== hdl/acked_serial_bit_sender_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the acked serial bit sender
// Implication checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ACKED_SERIAL_BIT_SENDER_CORE_MACROS_SVH
`define ACKED_SERIAL_BIT_SENDER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, disabled during reset
`define ASBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication on clk, disabled during reset
`define ASBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASBS_ASSERT_IMP(lbl, ante, cons, msg)
`define ASBS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/asbs_pkg.sv =====
// ---------------------------------------------------------------------------
// asbs_pkg
// Shared types and constants of the acked serial bit sender.
// ---------------------------------------------------------------------------
`default_nettype none

package asbs_pkg;

	localparam int DataBitsDefault = 8;
	localparam int ByteW   = 8;
	localparam int TriesW  = 3;
	localparam int TicksW  = 10;
	localparam int PeerW   = 22;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = PeerW;

	localparam logic [TriesW-1:0] TriesRst   = 3'd3;
	localparam logic [TicksW-1:0] TimeoutRst = 10'd100;
	localparam logic [PeerW-1:0]  PeerRst    = '0;

	// result queue depth: one for the beat waiting at the port, two in flight
	localparam int QDepth = 3;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 2;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_ACK   = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_TRIES = 2'd0,
		REG_TIMEOUT   = 2'd1,
		REG_PEER_ID   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             send_valid;
		logic             send_level;
		logic [PeerW-1:0] target_id;
		logic             byte_done;
		logic             load_taken;
		logic             failed;
		logic             busy_res;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/asbs_res_fifo.sv =====
// ---------------------------------------------------------------------------
// asbs_res_fifo
// Small result queue between the step logic and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module asbs_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  asbs_pkg::res_t    push_data,
	output logic              out_valid,
	input  logic              out_ready,
	output asbs_pkg::res_t    head,
	output logic [asbs_pkg::QCntW-1:0] count
);
	import asbs_pkg::*;

	res_t               mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/acked_serial_bit_sender_core.sv =====
// ---------------------------------------------------------------------------
// acked_serial_bit_sender_core
// Stop-and-wait serial bit sender with timeout resend and sticky failure.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action and data_byte: load a
//   word, acknowledge, timer tick or clear failure. Every input beat gives
//   exactly one result beat on the output channel (out_valid/out_ready):
//   the bit sent (if any), its target, byte done, load taken, failure and
//   busy status after the item.
//   An accepted beat is registered at the input stage, processed against
//   the transfer state and pushed into the result queue, whose head is
//   shown on the output. Throughput: one item per cycle while in_ready is
//   high; the state update is a single pass of counter and compare logic
//   between the input and result registers.
//   A three-entry result queue lets input beats keep flowing while one
//   result waits at the port. When the receiver stalls, in_ready drops
//   once the queue plus the input stage hold three items.
//   Reset (arst_n low) clears the transfer state, the failure flag and the
//   queue, and loads the default max_tries, timeout_ticks and peer_id.
//   The user writes configuration via cfg_we/cfg_index/cfg_data only while idle (unchecked).
// ---------------------------------------------------------------------------
`default_nettype none
`include "acked_serial_bit_sender_core_macros.svh"

module acked_serial_bit_sender_core #(
	parameter int DATA_BITS = asbs_pkg::DataBitsDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [asbs_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [asbs_pkg::CfgW-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [asbs_pkg::ByteW-1:0]   data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         send_valid,
	output logic                         send_level,
	output logic [asbs_pkg::PeerW-1:0]   target_id,
	output logic                         byte_done,
	output logic                         load_taken,
	output logic                         failed,
	output logic                         busy_res
);
	import asbs_pkg::*;

	localparam int PosW = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [PosW-1:0] PosTop = PosW'(DATA_BITS - 1);

	// configuration
	logic [TriesW-1:0] max_tries_q;
	logic [TicksW-1:0] timeout_ticks_q;
	logic [PeerW-1:0]  peer_id_q;

	// input stage
	logic              valid_s1;
	act_t              action_s1;
	logic [ByteW-1:0]  data_s1;

	// transfer state
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic [PosW-1:0]      pos_q, pos_d;
	logic [TriesW-1:0]    tries_q, tries_d;
	logic [TicksW-1:0]    wait_q, wait_d;
	logic                 busy_q, busy_d;
	logic                 fail_q, fail_d;

	logic [TicksW-1:0]    wait_inc;
	logic [DATA_BITS-1:0] load_word;
	res_t                 res;
	res_t                 head;
	logic [QCntW-1:0]     q_cnt;

	// occupancy of input stage plus queue never exceeds the queue depth
	assign in_ready = ((3'(q_cnt) + 3'(valid_s1)) < 3'(QDepth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q     <= TriesRst;
			timeout_ticks_q <= TimeoutRst;
			peer_id_q       <= PeerRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_TRIES: max_tries_q     <= cfg_data[TriesW-1:0];
				REG_TIMEOUT:   timeout_ticks_q <= cfg_data[TicksW-1:0];
				REG_PEER_ID:   peer_id_q       <= cfg_data[PeerW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= act_t'(action);
			data_s1   <= data_byte;
		end
	end

	assign wait_inc  = wait_q + 1'b1;
	assign load_word = DATA_BITS'(data_s1);

	always_comb begin
		shift_d = shift_q;
		pos_d   = pos_q;
		tries_d = tries_q;
		wait_d  = wait_q;
		busy_d  = busy_q;
		fail_d  = fail_q;
		res     = '0;
		unique case (action_s1)
			ACT_LOAD: begin
				if (!busy_q) begin
					shift_d        = load_word;
					pos_d          = PosTop;
					tries_d        = TriesW'(1);
					wait_d         = '0;
					busy_d         = 1'b1;
					res.load_taken = 1'b1;
					res.send_valid = 1'b1;
					res.send_level = load_word[DATA_BITS-1];
				end
			end
			ACT_ACK: begin
				if (busy_q) begin
					wait_d = '0;
					if (pos_q == '0) begin
						busy_d        = 1'b0;
						res.byte_done = 1'b1;
					end else begin
						pos_d          = pos_q - 1'b1;
						tries_d        = TriesW'(1);
						res.send_valid = 1'b1;
						res.send_level = shift_q[pos_q - 1'b1];
					end
				end
			end
			ACT_TICK: begin
				if (busy_q) begin
					wait_d = wait_inc;
					// zero timeout compares as always expired
					if (wait_inc >= timeout_ticks_q) begin
						wait_d = '0;
						if (tries_q < max_tries_q) begin
							tries_d        = tries_q + 1'b1;
							res.send_valid = 1'b1;
							res.send_level = shift_q[pos_q];
						end else begin
							fail_d = 1'b1;
							busy_d = 1'b0;
						end
					end
				end
			end
			ACT_CLEAR: begin
				fail_d = 1'b0;
			end
			default: ;
		endcase
		res.target_id = res.send_valid ? peer_id_q : '0;
		res.failed    = fail_d;
		res.busy_res  = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			pos_q   <= PosTop;
			tries_q <= '0;
			wait_q  <= '0;
			busy_q  <= 1'b0;
			fail_q  <= 1'b0;
		end else if (valid_s1) begin
			shift_q <= shift_d;
			pos_q   <= pos_d;
			tries_q <= tries_d;
			wait_q  <= wait_d;
			busy_q  <= busy_d;
			fail_q  <= fail_d;
		end
	end

	asbs_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.count     (q_cnt)
	);

	assign send_valid = head.send_valid;
	assign send_level = head.send_level;
	assign target_id  = head.target_id;
	assign byte_done  = head.byte_done;
	assign load_taken = head.load_taken;
	assign failed     = head.failed;
	assign busy_res   = head.busy_res;

	`ASBS_ASSERT_IMP(a_no_overflow, 1'b1, (3'(q_cnt) + 3'(valid_s1)) <= 3'(QDepth), "result queue overflow")
	`ASBS_ASSERT_IMP(a_busy_tries, busy_q, tries_q != '0, "busy with zero tries")
	`ASBS_ASSERT_IMP(a_done_no_send, valid_s1 && res.byte_done, !res.send_valid && !busy_d, "done with send")
	`ASBS_ASSERT_NXT(a_load_starts, valid_s1 && (action_s1 == ACT_LOAD) && !busy_q, busy_q && (tries_q == TriesW'(1)), "load did not start transfer")

endmodule

`default_nettype wire
